[src/bdq_pkg.sv]
// bdq_pkg: request and status codes shared by the bounded deque files
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned REQ_BITS    = 2;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_BITS-1:0] REQ_POP_BACK   = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

[src/bdq_ifs.sv]
// bdq_req_if, bdq_rsp_if: valid/ready channels of the bounded deque
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bdq_req_if #(
  parameter int unsigned WORD_BITS = 32
) ();
  import bdq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [REQ_BITS-1:0]         req_type;
  logic signed [WORD_BITS-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface bdq_rsp_if #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) ();
  import bdq_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pop_value;
  logic [CNT_BITS-1:0]         entry_count;
  logic                        is_empty;
  logic [STATUS_BITS-1:0]      status;

  modport source (output valid, pop_value, entry_count, is_empty, status, input ready);
  modport sink   (input valid, pop_value, entry_count, is_empty, status, output ready);
endinterface

`default_nettype wire

[src/bdq_store.sv]
// bdq_store: slot memory, one shared address, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bdq_store #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic                         re_i,
  input  wire logic [$clog2(DEPTH)-1:0]     addr_i,
  input  wire logic [WORD_BITS-1:0]         wdata_i,
  output      logic [WORD_BITS-1:0]         rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/bdq_ctrl.sv]
// bdq_ctrl: front pointer, entry count, request sequencing and result register
// depends on bdq_pkg, bdq_ifs; drives the port of bdq_store
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  bdq_req_if.sink                       req_i,
  bdq_rsp_if.source                     rsp_o,
  output      logic                     mem_we_o,
  output      logic                     mem_re_o,
  output      logic [$clog2(DEPTH)-1:0] mem_addr_o,
  output      logic [WORD_BITS-1:0]     mem_wdata_o,
  input  wire logic [WORD_BITS-1:0]     mem_rdata_i
);
  import bdq_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam int unsigned SUM_BITS = CNT_BITS + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic                   state_q, state_d;
  logic [PTR_BITS-1:0]    front_q, front_d;
  logic [CNT_BITS-1:0]    count_q, count_d;
  logic [STATUS_BITS-1:0] hold_status_q, hold_status_d;
  logic                   hold_pop_q, hold_pop_d;

  logic                   out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0]   out_value_q;
  logic [CNT_BITS-1:0]    out_count_q;
  logic                   out_empty_q;
  logic [STATUS_BITS-1:0] out_status_q;

  logic                   accept;
  logic                   load_out;
  logic                   is_full;
  logic                   is_none;
  logic [PTR_BITS-1:0]    front_inc;
  logic [PTR_BITS-1:0]    front_dec;
  logic [SUM_BITS-1:0]    end_sum;
  logic [SUM_BITS-1:0]    last_sum;
  logic [PTR_BITS-1:0]    end_pos;
  logic [PTR_BITS-1:0]    last_pos;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load_out    = (state_q == S_HOLD) && (!out_valid_q || rsp_o.ready);

  assign is_full = (count_q == CNT_BITS'(DEPTH));
  assign is_none = (count_q == '0);

  // ring positions; end sum below twice the depth, last sum too if nonempty
  assign front_inc = (front_q == PTR_BITS'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? PTR_BITS'(DEPTH - 1) : front_q - 1'b1;
  assign end_sum   = SUM_BITS'(front_q) + SUM_BITS'(count_q);
  assign last_sum  = end_sum - 1'b1;
  assign end_pos   = (end_sum >= SUM_BITS'(DEPTH)) ?
                     PTR_BITS'(end_sum - SUM_BITS'(DEPTH)) : PTR_BITS'(end_sum);
  assign last_pos  = (last_sum >= SUM_BITS'(DEPTH)) ?
                     PTR_BITS'(last_sum - SUM_BITS'(DEPTH)) : PTR_BITS'(last_sum);

  assign mem_wdata_o = req_i.push_value;

  always_comb begin
    state_d       = state_q;
    front_d       = front_q;
    count_d       = count_q;
    hold_status_d = hold_status_q;
    hold_pop_d    = hold_pop_q;
    mem_we_o      = 1'b0;
    mem_re_o      = 1'b0;
    mem_addr_o    = front_q;
    if (accept) begin
      state_d       = S_HOLD;
      hold_status_d = ST_DONE;
      hold_pop_d    = 1'b0;
      case (req_i.req_type)
        REQ_PUSH_FRONT: begin
          if (is_full) begin
            hold_status_d = ST_FULL;
          end else begin
            mem_we_o   = 1'b1;
            mem_addr_o = front_dec;
            front_d    = front_dec;
            count_d    = count_q + 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          if (is_full) begin
            hold_status_d = ST_FULL;
          end else begin
            mem_we_o   = 1'b1;
            mem_addr_o = end_pos;
            count_d    = count_q + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (is_none) begin
            hold_status_d = ST_EMPTY;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = front_q;
            front_d    = front_inc;
            count_d    = count_q - 1'b1;
            hold_pop_d = 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (is_none) begin
            hold_status_d = ST_EMPTY;
          end else begin
            mem_re_o   = 1'b1;
            mem_addr_o = last_pos;
            count_d    = count_q - 1'b1;
            hold_pop_d = 1'b1;
          end
        end
        default: begin
          hold_status_d = ST_DONE;
        end
      endcase
    end else if (load_out) begin
      state_d = S_IDLE;
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      front_q       <= '0;
      count_q       <= '0;
      hold_status_q <= ST_DONE;
      hold_pop_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      front_q       <= front_d;
      count_q       <= count_d;
      hold_status_q <= hold_status_d;
      hold_pop_q    <= hold_pop_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // read data stays in the store's output register until the result loads
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q  <= hold_pop_q ? mem_rdata_i : '0;
      out_count_q  <= count_q;
      out_empty_q  <= (count_q == '0);
      out_status_q <= hold_status_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pop_value   = out_value_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.status      = out_status_q;

  count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_HOLD) && !req_i.ready)
    else $error("transfer accepted without entering hold");

  pop_changes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mem_re_o) |=> (count_q == $past(count_q) - 1'b1) && hold_pop_q)
    else $error("pop read without count decrement");

  empty_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |->
      (out_count_q == '0) && out_empty_q && (out_value_q == '0))
    else $error("pop on empty with nonzero result");

  full_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |->
      (out_count_q == CNT_BITS'(DEPTH)) && (out_value_q == '0))
    else $error("dropped push with wrong result");

endmodule

`default_nettype wire

[src/bounded_deque.sv]
// bounded_deque: push or pop at either end of a ring of DEPTH signed words
// results are registered: an accepted request waits in the hold state
// until the output register is free, then loads it; requests are taken only while idle
// a new request is taken while the previous result still waits in the output register
// reset clears the front pointer and the count; slot contents stay undefined, no clear pass
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(DEPTH);

  logic                 mem_we;
  logic                 mem_re;
  logic [PTR_BITS-1:0]  mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  bdq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  bdq_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
